FILE: hdl/table_constraint_filter_macros.svh
// ----------------------------------------------------------------------------
// Table constraint filter assertion macros
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TABLE_CONSTRAINT_FILTER_MACROS_SVH
`define TABLE_CONSTRAINT_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define TCF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("table constraint filter check failed");
`define TCF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("table constraint filter check failed");
`else
`define TCF_ASSERT_IMPL(lbl, ante, cons)
`define TCF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// Table constraint filter package
// Command, status, register index and sequencer state codes.
// ----------------------------------------------------------------------------
package tcf_pkg;

    typedef enum logic [2:0] {
        CMD_WR_TUPLE  = 3'd0,
        CMD_WR_DOMAIN = 3'd1,
        CMD_WR_ASSIGN = 3'd2,
        CMD_RESTORE   = 3'd3,
        CMD_FILTER    = 3'd4,
        CMD_RD_DOMAIN = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_CONSISTENT = 2'd1,
        ST_FAILED     = 2'd2,
        ST_ENTAILED   = 2'd3
    } status_t;

    localparam logic [1:0] CFG_ARITY       = 2'd0;
    localparam logic [1:0] CFG_TUPLE_COUNT = 2'd1;

    localparam int ENTRY_W = 7;  // wildcard mark over a 6-bit value index

    typedef enum logic [8:0] {
        S_CLEAR   = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_CHECK   = 9'b000000100,
        S_LIVE_RD = 9'b000001000,
        S_LIVE_WT = 9'b000010000,
        S_ENT_RD  = 9'b000100000,
        S_ENT_WT  = 9'b001000000,
        S_SUPP    = 9'b010000000,
        S_PRUNE   = 9'b100000000
    } state_t;

endpackage

FILE: hdl/table_constraint_filter.sv
// ----------------------------------------------------------------------------
// Table constraint filter
// Tabular reduction over one tuple table with per-variable domain bitmaps.
// ----------------------------------------------------------------------------
// Writes and the domain read return their item in the cycle after acceptance.
// Restore sweeps the live-row memory one row per cycle over all MAX_TUPLES rows;
// the same sweep runs after reset, and no item is accepted during it.
// Filter first checks the domain of each variable in turn, then per row reads
// the live mark (read and wait states), reads each table entry through the
// entry memory's one read port (read and wait states), and updates support
// for a valid row, then runs one pruning step.
module table_constraint_filter #(
    parameter int MAX_ARITY  = 8,
    parameter int MAX_DOMAIN = 64,
    parameter int MAX_TUPLES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [9:0]  row_index,
    input  logic [2:0]  var_position,
    input  logic [5:0]  value_index,
    input  logic        is_wildcard,
    input  logic        bit_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        read_bit
);

`include "table_constraint_filter_macros.svh"

    localparam int RW = (MAX_TUPLES > 1) ? $clog2(MAX_TUPLES) : 1;
    localparam int PW = (MAX_ARITY > 1) ? $clog2(MAX_ARITY) : 1;
    localparam int DW = $clog2(MAX_DOMAIN);
    localparam int NW = $clog2(MAX_ARITY + 1);
    localparam int CW = $clog2(MAX_TUPLES + 1);
    localparam int ED = MAX_TUPLES * MAX_ARITY;
    localparam int AW = (ED > 1) ? $clog2(ED) : 1;
    localparam int EW = tcf_pkg::ENTRY_W;

    tcf_pkg::state_t state_reg, state_next;

    logic [3:0]            arity_reg;
    logic [10:0]           tuple_count_reg;
    logic [RW-1:0]         r_reg, r_next;
    logic [NW-1:0]         p_reg, p_next;
    logic                  univ_reg, univ_next;
    logic                  any_valid_reg, any_valid_next;
    logic                  clr_reply_reg, clr_reply_next;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            status_reg, status_next;
    logic                  read_bit_reg, read_bit_next;
    logic [MAX_ARITY-1:0]  assigned_reg, assigned_next;
    logic [MAX_ARITY-1:0]  inq_reg, inq_next;
    logic [MAX_DOMAIN-1:0] domain_reg [MAX_ARITY];
    logic [MAX_DOMAIN-1:0] domain_next [MAX_ARITY];
    logic [MAX_DOMAIN-1:0] support_reg [MAX_ARITY];
    logic [MAX_DOMAIN-1:0] support_next [MAX_ARITY];
    logic [EW-1:0]         rowbuf_reg [MAX_ARITY];
    logic [EW-1:0]         rowbuf_next [MAX_ARITY];

    logic [EW-1:0]         ent_mem [ED];
    logic [EW-1:0]         ent_rd_reg;
    logic                  ent_we;
    logic [AW-1:0]         ent_waddr;
    logic [AW-1:0]         ent_addr;
    logic                  live_mem [MAX_TUPLES];
    logic                  live_rd_reg;
    logic                  live_we;
    logic                  live_wdata;

    logic [NW-1:0]         n_eff;
    logic [CW-1:0]         rows_eff;
    logic [PW-1:0]         dom_ridx;
    logic [MAX_DOMAIN-1:0] dom_sel;
    logic                  in_acc;
    logic                  pos_ok;
    logic                  val_ok;

    assign cfg_ready = 1'b1;
    assign in_stall  = !((state_reg == tcf_pkg::S_IDLE) && (!out_valid_reg || !out_stall));
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign read_bit  = read_bit_reg;

    assign n_eff    = (int'(arity_reg) > MAX_ARITY) ? NW'(MAX_ARITY) : NW'(arity_reg);
    assign rows_eff = (int'(tuple_count_reg) > MAX_TUPLES) ? CW'(MAX_TUPLES)
                                                            : CW'(tuple_count_reg);
    assign pos_ok   = int'(var_position) < MAX_ARITY;
    assign val_ok   = int'(value_index) < MAX_DOMAIN;
    assign dom_ridx = (state_reg == tcf_pkg::S_IDLE) ? PW'(var_position) : p_reg[PW-1:0];
    assign dom_sel  = domain_reg[dom_ridx];

    assign ent_waddr = AW'(int'(row_index) * MAX_ARITY + int'(var_position));
    assign ent_addr  = AW'(int'(r_reg) * MAX_ARITY + int'(p_reg));

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= {is_wildcard, value_index};
        end
        ent_rd_reg <= ent_mem[ent_addr];
    end

    always_ff @(posedge clk)
    begin
        if (live_we)
        begin
            live_mem[r_reg] <= live_wdata;
        end
        live_rd_reg <= live_mem[r_reg];
    end

    always_comb
    begin
        logic       row_done;
        logic       finish;
        logic [1:0] fin_status;
        logic       wild;
        logic [5:0] val;
        logic       inb;
        logic       single;
        logic       univ_now;
        logic       found;
        logic [MAX_DOMAIN-1:0] sb;

        state_next     = state_reg;
        r_next         = r_reg;
        p_next         = p_reg;
        univ_next      = univ_reg;
        any_valid_next = any_valid_reg;
        clr_reply_next = clr_reply_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        read_bit_next  = read_bit_reg;
        assigned_next  = assigned_reg;
        inq_next       = inq_reg;
        domain_next    = domain_reg;
        support_next   = support_reg;
        rowbuf_next    = rowbuf_reg;
        ent_we         = 1'b0;
        live_we        = 1'b0;
        live_wdata     = 1'b0;
        row_done       = 1'b0;
        finish         = 1'b0;
        fin_status     = tcf_pkg::ST_DONE;
        found          = 1'b0;
        sb             = '0;

        wild     = ent_rd_reg[EW-1];
        val      = ent_rd_reg[5:0];
        inb      = (int'(val) < MAX_DOMAIN) && dom_sel[DW'(val)];
        single   = ((dom_sel & (dom_sel - 1'b1)) == '0);
        univ_now = univ_reg && (wild || single);

        unique case (state_reg)
            tcf_pkg::S_CLEAR:
            begin
                live_we    = 1'b1;
                live_wdata = 1'b1;
                if (r_reg == RW'(MAX_TUPLES - 1))
                begin
                    r_next = '0;
                    if (clr_reply_reg)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        state_next = tcf_pkg::S_IDLE;
                    end
                end
                else
                begin
                    r_next = r_reg + 1'b1;
                end
            end
            tcf_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    case (cmd)
                        tcf_pkg::CMD_WR_TUPLE:
                        begin
                            ent_we = (int'(row_index) < MAX_TUPLES) && pos_ok;
                            finish = 1'b1;
                        end
                        tcf_pkg::CMD_WR_DOMAIN:
                        begin
                            if (pos_ok && val_ok)
                            begin
                                domain_next[dom_ridx][DW'(value_index)] = bit_value;
                            end
                            finish = 1'b1;
                        end
                        tcf_pkg::CMD_WR_ASSIGN:
                        begin
                            if (pos_ok)
                            begin
                                assigned_next[dom_ridx] = bit_value;
                            end
                            finish = 1'b1;
                        end
                        tcf_pkg::CMD_RESTORE:
                        begin
                            r_next         = '0;
                            clr_reply_next = 1'b1;
                            state_next     = tcf_pkg::S_CLEAR;
                        end
                        tcf_pkg::CMD_FILTER:
                        begin
                            p_next         = '0;
                            any_valid_next = 1'b0;
                            for (int q = 0; q < MAX_ARITY; q++)
                            begin
                                support_next[q] = '0;
                                inq_next[q]     = !assigned_reg[q] && (q < int'(n_eff));
                            end
                            state_next = tcf_pkg::S_CHECK;
                        end
                        tcf_pkg::CMD_RD_DOMAIN:
                        begin
                            finish = 1'b1;
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            tcf_pkg::S_CHECK:
            begin
                if (p_reg == n_eff)
                begin
                    p_next = '0;
                    if (rows_eff == '0)
                    begin
                        state_next = tcf_pkg::S_PRUNE;
                    end
                    else
                    begin
                        r_next     = RW'(rows_eff - 1'b1);
                        state_next = tcf_pkg::S_LIVE_RD;
                    end
                end
                else if (dom_sel == '0)
                begin
                    finish     = 1'b1;
                    fin_status = tcf_pkg::ST_FAILED;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                end
            end
            tcf_pkg::S_LIVE_RD:
            begin
                state_next = tcf_pkg::S_LIVE_WT;
            end
            tcf_pkg::S_LIVE_WT:
            begin
                p_next    = '0;
                univ_next = 1'b1;
                if (!live_rd_reg)
                begin
                    row_done = 1'b1;
                end
                else if (n_eff == '0)
                begin
                    finish     = 1'b1;
                    fin_status = tcf_pkg::ST_ENTAILED;
                end
                else
                begin
                    state_next = tcf_pkg::S_ENT_RD;
                end
            end
            tcf_pkg::S_ENT_RD:
            begin
                state_next = tcf_pkg::S_ENT_WT;
            end
            tcf_pkg::S_ENT_WT:
            begin
                rowbuf_next[p_reg[PW-1:0]] = ent_rd_reg;
                if (!wild && !inb)
                begin
                    // kill the row: a fixed value has left its domain
                    live_we  = 1'b1;
                    row_done = 1'b1;
                end
                else
                begin
                    univ_next = univ_now;
                    p_next    = p_reg + 1'b1;
                    if (p_reg + 1'b1 == n_eff)
                    begin
                        if (univ_now)
                        begin
                            finish     = 1'b1;
                            fin_status = tcf_pkg::ST_ENTAILED;
                        end
                        else
                        begin
                            state_next = tcf_pkg::S_SUPP;
                        end
                    end
                    else
                    begin
                        state_next = tcf_pkg::S_ENT_RD;
                    end
                end
            end
            tcf_pkg::S_SUPP:
            begin
                any_valid_next = 1'b1;
                for (int q = 0; q < MAX_ARITY; q++)
                begin
                    if (inq_reg[q])
                    begin
                        if (rowbuf_reg[q][EW-1])
                        begin
                            inq_next[q] = 1'b0;
                        end
                        else
                        begin
                            sb = support_reg[q] | (MAX_DOMAIN'(1) << rowbuf_reg[q][5:0]);
                            support_next[q] = sb;
                            // drop a variable once every domain value has support
                            if (sb == domain_reg[q])
                            begin
                                inq_next[q] = 1'b0;
                            end
                        end
                    end
                end
                row_done = 1'b1;
            end
            tcf_pkg::S_PRUNE:
            begin
                finish     = 1'b1;
                fin_status = tcf_pkg::ST_CONSISTENT;
                if (any_valid_reg)
                begin
                    for (int q = 0; q < MAX_ARITY; q++)
                    begin
                        if (inq_reg[q])
                        begin
                            domain_next[q] = domain_reg[q] & support_reg[q];
                        end
                    end
                end
                else
                begin
                    // no valid row: the first queued variable wipes out
                    for (int q = 0; q < MAX_ARITY; q++)
                    begin
                        if (inq_reg[q] && !found)
                        begin
                            domain_next[q] = '0;
                            found          = 1'b1;
                        end
                    end
                    if (found)
                    begin
                        fin_status = tcf_pkg::ST_FAILED;
                    end
                end
            end
            default:
            begin
                state_next = tcf_pkg::S_IDLE;
            end
        endcase

        if (row_done)
        begin
            if (r_reg == '0)
            begin
                state_next = tcf_pkg::S_PRUNE;
            end
            else
            begin
                r_next     = r_reg - 1'b1;
                state_next = tcf_pkg::S_LIVE_RD;
            end
        end

        if (finish)
        begin
            state_next     = tcf_pkg::S_IDLE;
            clr_reply_next = 1'b0;
            out_valid_next = 1'b1;
            status_next    = fin_status;
            read_bit_next  = (state_reg == tcf_pkg::S_IDLE) &&
                             (cmd == tcf_pkg::CMD_RD_DOMAIN) && pos_ok && val_ok &&
                             dom_sel[DW'(value_index)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tcf_pkg::S_CLEAR;
            arity_reg       <= 4'd1;
            tuple_count_reg <= '0;
            r_reg           <= '0;
            p_reg           <= '0;
            univ_reg        <= 1'b0;
            any_valid_reg   <= 1'b0;
            clr_reply_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            status_reg      <= '0;
            read_bit_reg    <= 1'b0;
            assigned_reg    <= '0;
            inq_reg         <= '0;
            for (int q = 0; q < MAX_ARITY; q++)
            begin
                domain_reg[q] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            p_reg         <= p_next;
            univ_reg      <= univ_next;
            any_valid_reg <= any_valid_next;
            clr_reply_reg <= clr_reply_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            read_bit_reg  <= read_bit_next;
            assigned_reg  <= assigned_next;
            inq_reg       <= inq_next;
            domain_reg    <= domain_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tcf_pkg::CFG_ARITY)
                begin
                    arity_reg <= cfg_data[3:0];
                end
                else if (cfg_index == tcf_pkg::CFG_TUPLE_COUNT)
                begin
                    tuple_count_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        support_reg <= support_next;
        rowbuf_reg  <= rowbuf_next;
    end

    `TCF_ASSERT_IMPL(a_clear_blocks_input, state_reg == tcf_pkg::S_CLEAR, in_stall)
    `TCF_ASSERT_IMPL(a_supp_row_complete, state_reg == tcf_pkg::S_SUPP, p_reg == n_eff)
    `TCF_ASSERT_NEXT(a_filter_leaves_idle, in_acc && (cmd == tcf_pkg::CMD_FILTER), state_reg == tcf_pkg::S_CHECK && !out_valid_reg)

endmodule
